// ----- rtl/core/char_lcd_terminal_writer_macros.svh -----
// Assertion macros shared by the checker of the character LCD terminal writer.
`ifndef CHAR_LCD_TERMINAL_WRITER_MACROS_SVH
`define CHAR_LCD_TERMINAL_WRITER_MACROS_SVH
// Implication in the same cycle, sampled on clk and quiet during reset.
`define CLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clt checker: same-cycle property failed");
// Implication into the next cycle, sampled on clk and quiet during reset.
`define CLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clt checker: next-cycle property failed");
`endif

// ----- rtl/core/clt_pkg.sv -----
// Package with the types and constants of the character LCD terminal writer.
`timescale 1ns / 1ps
`default_nettype none
package clt_pkg;

  localparam int TAB_STOP_DEF = 4;
  localparam int MAX_XFERS    = 24;
  localparam int CNT_W        = 5;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_FOUR_BIT  = 3'd0,
    REG_TWO_LINE  = 3'd1,
    REG_ROWS      = 3'd2,
    REG_COLUMNS   = 3'd3,
    REG_ROW_BREAK = 3'd4,
    REG_LINE_END  = 3'd5
  } reg_idx_t;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SHIFT     = 8'h10;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_FUNC      = 8'h20;
  localparam logic [7:0] FUNC_8BIT     = 8'h10;
  localparam logic [7:0] FUNC_2LINE    = 8'h08;
  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] ADDR_LINE2    = 8'h40;
  localparam logic [7:0] WAKE_8BIT     = 8'h30;
  localparam logic [7:0] WAKE_4BIT     = 8'h03;
  localparam logic [7:0] NIB_4BIT      = 8'h02;

  localparam logic [1:0] HOLD_NORMAL = 2'd0;
  localparam logic [1:0] HOLD_CLEAR  = 2'd1;
  localparam logic [1:0] HOLD_100MS  = 2'd2;
  localparam logic [1:0] HOLD_10MS   = 2'd3;

  typedef struct packed {
    logic       four_bit_bus;
    logic       two_line_mode;
    logic [2:0] text_rows;
    logic [5:0] text_columns;
    logic [5:0] row_break;
    logic [5:0] line_end;
  } cfg_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_value;
    logic [1:0] hold_code;
    logic       last;
  } xfer_t;

  typedef struct packed {
    logic  push;
    logic  flush;
    xfer_t data;
  } buf_ctl_t;

  typedef struct packed {
    logic room;
    logic out_free;
  } buf_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUT_DATA,
    S_PUT_ADV,
    S_PUT_SPLIT,
    S_PUT_TAB,
    S_POS_LOAD,
    S_POS_DIV,
    S_POS_CMD,
    S_CLEAR,
    S_INIT_WAKE,
    S_INIT_CMD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/clt_ifs.sv -----
// Channel interfaces: request input, bus transfer output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface clt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [1:0] target_row;
  logic [5:0] target_column;
  modport source (output valid, kind, char_code, target_row, target_column, input ready);
  modport sink (input valid, kind, char_code, target_row, target_column, output ready);
endinterface

interface clt_xfer_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [7:0] bus_value;
  logic [1:0] hold_code;
  logic       last;
  modport source (output valid, register_select, bus_value, hold_code, last, input ready);
  modport sink (input valid, register_select, bus_value, hold_code, last, output ready);
endinterface

interface clt_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/clt_cfg_regs.sv -----
// Configuration register file.
`timescale 1ns / 1ps
`default_nettype none
module clt_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst_n,
  clt_cfg_if.sink     cfg_ch,
  output clt_pkg::cfg_t cfg
);

  clt_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.four_bit_bus  <= 1'b1;
      cfg_r.two_line_mode <= 1'b1;
      cfg_r.text_rows     <= 3'd2;
      cfg_r.text_columns  <= 6'd16;
      cfg_r.row_break     <= 6'd16;
      cfg_r.line_end      <= 6'd16;
    end else if (cfg_ch.valid) begin
      case (clt_pkg::reg_idx_t'(cfg_ch.index))
        clt_pkg::REG_FOUR_BIT:  cfg_r.four_bit_bus  <= cfg_ch.data[0];
        clt_pkg::REG_TWO_LINE:  cfg_r.two_line_mode <= cfg_ch.data[0];
        clt_pkg::REG_ROWS:      cfg_r.text_rows     <= cfg_ch.data[2:0];
        clt_pkg::REG_COLUMNS:   cfg_r.text_columns  <= cfg_ch.data;
        clt_pkg::REG_ROW_BREAK: cfg_r.row_break     <= cfg_ch.data;
        clt_pkg::REG_LINE_END:  cfg_r.line_end      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/clt_mod_unit.sv -----
// Shared remainder unit: one conditional subtraction per cycle.
`timescale 1ns / 1ps
`default_nettype none
module clt_mod_unit (
  input  wire logic       clk,
  input  wire logic       load,
  input  wire logic [5:0] dividend,
  input  wire logic [5:0] divisor,
  output logic      [5:0] rem,
  output logic            done
);

  logic [5:0] rem_r;

  // A zero divisor leaves the dividend as the remainder.
  assign done = (divisor == 6'd0) || (rem_r < divisor);
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dividend;
    end else if (!done) begin
      rem_r <= rem_r - divisor;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/clt_xfer_buf.sv -----
// One pending transfer plus the output register; marks the final transfer.
`timescale 1ns / 1ps
`default_nettype none
module clt_xfer_buf (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  clt_pkg::buf_ctl_t ctl,
  output clt_pkg::buf_sts_t sts,
  clt_xfer_if.source       out_ch
);

  logic           pend_v_r, pend_v_nxt;
  clt_pkg::xfer_t pend_r, pend_nxt;
  logic           out_v_r, out_v_nxt;
  clt_pkg::xfer_t out_r, out_nxt;
  logic           out_free;

  assign out_free     = !out_v_r || out_ch.ready;
  assign sts.out_free = out_free;
  assign sts.room     = !pend_v_r || out_free;

  assign out_ch.valid           = out_v_r;
  assign out_ch.register_select = out_r.register_select;
  assign out_ch.bus_value       = out_r.bus_value;
  assign out_ch.hold_code       = out_r.hold_code;
  assign out_ch.last            = out_r.last;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    if (ctl.push) begin
      // A newer transfer proves the pending one is not the last.
      if (pend_v_r) begin
        out_nxt      = pend_r;
        out_nxt.last = 1'b0;
        out_v_nxt    = 1'b1;
      end
      pend_nxt   = ctl.data;
      pend_v_nxt = 1'b1;
    end else if (ctl.flush && pend_v_r && out_free) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/clt_seq.sv -----
// Request sequencer: cursor tracking, command expansion and nibble splitting.
`timescale 1ns / 1ps
`default_nettype none
module clt_seq #(
  parameter int TAB_STOP = clt_pkg::TAB_STOP_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  clt_req_if.sink           in_ch,
  input  clt_pkg::cfg_t     cfg,
  input  clt_pkg::buf_sts_t sts,
  output clt_pkg::buf_ctl_t ctl
);

  // Columns that sit on a tab stop, worked out at elaboration.
  function automatic logic [63:0] tab_marks();
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (i % TAB_STOP) == 0;
    end
    return m;
  endfunction

  localparam logic [63:0] TAB_ALIGNED = tab_marks();

  clt_pkg::state_t state_r, state_nxt;
  clt_pkg::state_t ret_r, ret_nxt;
  logic [7:0] pchar_r, pchar_nxt;
  logic       tab_r, tab_nxt;
  logic [1:0] row_r, row_nxt;
  logic [5:0] col_r, col_nxt;
  logic [1:0] pos_row_r, pos_row_nxt;
  logic [5:0] pos_col_r, pos_col_nxt;
  logic [1:0] istep_r, istep_nxt;
  logic       nib_r;
  logic [clt_pkg::CNT_W-1:0] cnt_r;

  logic       emit, raw, rs;
  logic [7:0] val;
  logic [1:0] hold;
  logic       hi_phase, cap, emit_ok, step_done;
  logic       accept, split, rows4, q_flag, mod_load, mod_done;
  logic [5:0] rem, divisor;
  logic [1:0] nl_row;
  logic [7:0] addr, func_cmd, wake;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == clt_pkg::S_IDLE);

  assign split  = cfg.row_break > cfg.line_end;
  assign rows4  = cfg.text_rows == 3'd4;
  assign nl_row = ({1'b0, row_r + 2'd1} == cfg.text_rows) ? 2'd0 : row_r + 2'd1;
  assign divisor = split ? cfg.line_end : (rows4 ? cfg.row_break : 6'd0);
  assign q_flag = (cfg.line_end != 6'd0) && (pos_col_r >= cfg.line_end);
  assign mod_load = (state_r == clt_pkg::S_POS_LOAD);

  clt_mod_unit u_mod (
    .clk      (clk),
    .load     (mod_load),
    .dividend (pos_col_r),
    .divisor  (divisor),
    .rem      (rem),
    .done     (mod_done)
  );

  always_comb begin
    if (split) begin
      addr = (q_flag ? clt_pkg::ADDR_LINE2 : 8'd0) | {2'b00, rem};
    end else if (rows4) begin
      addr = (pos_row_r[0] ? clt_pkg::ADDR_LINE2 : 8'd0)
           + (pos_row_r[1] ? {2'b00, cfg.row_break} : 8'd0)
           + {2'b00, rem};
    end else begin
      addr = ((pos_row_r != 2'd0) ? clt_pkg::ADDR_LINE2 : 8'd0) | {2'b00, pos_col_r};
    end
  end

  assign func_cmd = clt_pkg::CMD_FUNC
                  | (cfg.four_bit_bus ? 8'd0 : clt_pkg::FUNC_8BIT)
                  | (cfg.two_line_mode ? clt_pkg::FUNC_2LINE : 8'd0);
  assign wake = cfg.four_bit_bus ? clt_pkg::WAKE_4BIT : clt_pkg::WAKE_8BIT;

  // Output block: what the current state puts on the transfer path.
  always_comb begin
    emit = 1'b0;
    raw  = 1'b0;
    rs   = 1'b0;
    val  = 8'd0;
    hold = clt_pkg::HOLD_NORMAL;
    case (state_r)
      clt_pkg::S_PUT_DATA: begin
        emit = 1'b1;
        rs   = 1'b1;
        val  = pchar_r;
      end
      clt_pkg::S_POS_CMD: begin
        emit = 1'b1;
        val  = addr | clt_pkg::CMD_SET_ADDR;
      end
      clt_pkg::S_CLEAR: begin
        emit = 1'b1;
        val  = clt_pkg::CMD_CLEAR;
        hold = clt_pkg::HOLD_CLEAR;
      end
      clt_pkg::S_INIT_WAKE: begin
        emit = 1'b1;
        raw  = 1'b1;
        case (istep_r)
          2'd0, 2'd1: begin
            val  = wake;
            hold = clt_pkg::HOLD_100MS;
          end
          2'd2: begin
            val  = wake;
            hold = clt_pkg::HOLD_10MS;
          end
          default: val = clt_pkg::NIB_4BIT;
        endcase
      end
      clt_pkg::S_INIT_CMD: begin
        emit = 1'b1;
        case (istep_r)
          2'd0:    val = func_cmd;
          2'd1:    val = clt_pkg::CMD_SHIFT;
          2'd2:    val = clt_pkg::CMD_DISP_ON;
          default: val = clt_pkg::CMD_ENTRY;
        endcase
      end
      default: ;
    endcase
  end

  assign hi_phase  = cfg.four_bit_bus && !raw && !nib_r;
  assign cap       = cnt_r >= clt_pkg::CNT_W'(clt_pkg::MAX_XFERS);
  assign emit_ok   = cap || sts.room;
  assign step_done = emit && emit_ok && !hi_phase;

  always_comb begin
    ctl.push                 = emit && emit_ok && !cap;
    ctl.flush                = (state_r == clt_pkg::S_DONE);
    ctl.data.register_select = rs;
    ctl.data.last            = 1'b0;
    ctl.data.hold_code       = hi_phase ? clt_pkg::HOLD_NORMAL : hold;
    if (raw || !cfg.four_bit_bus) begin
      ctl.data.bus_value = val;
    end else if (!nib_r) begin
      ctl.data.bus_value = {4'd0, val[7:4]};
    end else begin
      ctl.data.bus_value = {4'd0, val[3:0]};
    end
  end

  // Next-state block, with the cursor and position registers.
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    pchar_nxt   = pchar_r;
    tab_nxt     = tab_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    istep_nxt   = istep_r;
    case (state_r)
      clt_pkg::S_IDLE: begin
        if (accept) begin
          istep_nxt = 2'd0;
          case (clt_pkg::kind_t'(in_ch.kind))
            clt_pkg::KIND_PUT: begin
              if (in_ch.char_code == clt_pkg::CHAR_NL) begin
                pos_row_nxt = nl_row;
                pos_col_nxt = 6'd0;
                ret_nxt     = clt_pkg::S_DONE;
                state_nxt   = clt_pkg::S_POS_LOAD;
              end else begin
                tab_nxt   = in_ch.char_code == clt_pkg::CHAR_TAB;
                pchar_nxt = tab_nxt ? clt_pkg::CHAR_SPACE : in_ch.char_code;
                state_nxt = clt_pkg::S_PUT_DATA;
              end
            end
            clt_pkg::KIND_MOVE: begin
              pos_row_nxt = in_ch.target_row;
              pos_col_nxt = in_ch.target_column;
              ret_nxt     = clt_pkg::S_DONE;
              state_nxt   = clt_pkg::S_POS_LOAD;
            end
            clt_pkg::KIND_CLEAR: state_nxt = clt_pkg::S_CLEAR;
            default:             state_nxt = clt_pkg::S_INIT_WAKE;
          endcase
        end
      end
      clt_pkg::S_PUT_DATA: begin
        if (step_done) begin
          col_nxt   = col_r + 6'd1;
          state_nxt = clt_pkg::S_PUT_ADV;
        end
      end
      clt_pkg::S_PUT_ADV: begin
        if (col_r == cfg.text_columns) begin
          pos_row_nxt = nl_row;
          pos_col_nxt = 6'd0;
          ret_nxt     = clt_pkg::S_PUT_SPLIT;
          state_nxt   = clt_pkg::S_POS_LOAD;
        end else begin
          state_nxt = clt_pkg::S_PUT_SPLIT;
        end
      end
      clt_pkg::S_PUT_SPLIT: begin
        if (split) begin
          pos_row_nxt = row_r;
          pos_col_nxt = col_r;
          ret_nxt     = clt_pkg::S_PUT_TAB;
          state_nxt   = clt_pkg::S_POS_LOAD;
        end else begin
          state_nxt = clt_pkg::S_PUT_TAB;
        end
      end
      clt_pkg::S_PUT_TAB: begin
        if (tab_r && !TAB_ALIGNED[col_r]) begin
          state_nxt = clt_pkg::S_PUT_DATA;
        end else begin
          state_nxt = clt_pkg::S_DONE;
        end
      end
      clt_pkg::S_POS_LOAD: state_nxt = clt_pkg::S_POS_DIV;
      clt_pkg::S_POS_DIV: begin
        if (mod_done) begin
          state_nxt = clt_pkg::S_POS_CMD;
        end
      end
      clt_pkg::S_POS_CMD: begin
        if (step_done) begin
          row_nxt   = pos_row_r;
          col_nxt   = pos_col_r;
          state_nxt = ret_r;
        end
      end
      clt_pkg::S_CLEAR: begin
        if (step_done) begin
          row_nxt   = 2'd0;
          col_nxt   = 6'd0;
          state_nxt = clt_pkg::S_DONE;
        end
      end
      clt_pkg::S_INIT_WAKE: begin
        if (step_done) begin
          if (istep_r == 2'd3 || (istep_r == 2'd2 && !cfg.four_bit_bus)) begin
            istep_nxt = 2'd0;
            state_nxt = clt_pkg::S_INIT_CMD;
          end else begin
            istep_nxt = istep_r + 2'd1;
          end
        end
      end
      clt_pkg::S_INIT_CMD: begin
        if (step_done) begin
          istep_nxt = istep_r + 2'd1;
          if (istep_r == 2'd3) begin
            state_nxt = clt_pkg::S_CLEAR;
          end
        end
      end
      clt_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt = clt_pkg::S_IDLE;
        end
      end
      default: state_nxt = clt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::S_IDLE;
      ret_r   <= clt_pkg::S_DONE;
      row_r   <= 2'd0;
      col_r   <= 6'd0;
      istep_r <= 2'd0;
      nib_r   <= 1'b0;
      cnt_r   <= '0;
      tab_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      istep_r <= istep_nxt;
      tab_r   <= tab_nxt;
      if (accept) begin
        nib_r <= 1'b0;
        cnt_r <= '0;
      end else if (emit && emit_ok) begin
        nib_r <= hi_phase;
        if (!cap) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pchar_r   <= pchar_nxt;
    pos_row_r <= pos_row_nxt;
    pos_col_r <= pos_col_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/char_lcd_terminal_writer.sv -----
// Top level of the character LCD terminal writer.
// Usage:
// The in_ch channel takes one request at a time: put a character, move the
// cursor, clear the display, or run the power-up initialization. Each request
// expands into one or more bus transfers on out_ch, each with a register
// select bit, a bus byte (or a nibble in bits 3..0 in 4-bit mode), a hold
// code for the wait after the strobe, and a last flag on the final transfer.
// The cfg_ch channel writes the layout registers; it is always ready and must
// only be used while no request is in flight.
// A request is taken only when the sequencer is idle. Each command or character
// byte is one transfer, or two nibble transfers in 4-bit mode; every set-address
// command first passes the load and divide states, where the shared remainder
// unit subtracts until done (up to 63 subtractions), and a character passes the
// advance, split and tab bookkeeping states after its data transfer.
// One transfer is held back until the next one exists so the last flag can
// be set; a final flush cycle releases it.
// Synchronous active-low reset clears the cursor, the sequencer and the
// output valid, and loads the default layout (4-bit bus, 2 rows of 16).
// When the receiver stalls, the output register holds its transfer and the
// sequencer waits; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module char_lcd_terminal_writer #(
  parameter int TAB_STOP = clt_pkg::TAB_STOP_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  clt_req_if.sink    in_ch,
  clt_xfer_if.source out_ch,
  clt_cfg_if.sink    cfg_ch
);

  clt_pkg::cfg_t     cfg;
  clt_pkg::buf_ctl_t buf_ctl;
  clt_pkg::buf_sts_t buf_sts;

  // Layout registers.
  clt_cfg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Sequencer with the shared remainder unit inside.
  clt_seq #(
    .TAB_STOP (TAB_STOP)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .sts   (buf_sts),
    .ctl   (buf_ctl)
  );

  // Pending transfer and output register.
  clt_xfer_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (buf_ctl),
    .sts    (buf_sts),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/core/clt_checker.sv -----
// Port-level checker for the character LCD terminal writer, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
`include "char_lcd_terminal_writer_macros.svh"
module clt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_rs,
  input wire logic [7:0] out_bus,
  input wire logic [1:0] out_hold,
  input wire logic       out_last
);

  `CLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus) && $stable(out_last))
  `CLT_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `CLT_ASSERT_NOW(a_data_no_wait, out_valid && out_rs, out_hold == clt_pkg::HOLD_NORMAL)
  `CLT_ASSERT_NOW(a_clear_last, out_valid && out_hold == clt_pkg::HOLD_CLEAR, !out_rs && out_bus == 8'd1 && out_last)

endmodule

bind char_lcd_terminal_writer clt_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rs    (out_ch.register_select),
  .out_bus   (out_ch.bus_value),
  .out_hold  (out_ch.hold_code),
  .out_last  (out_ch.last)
);
`default_nettype wire
